// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds.
`define LFR_NEVER(lbl, clk, rstn, expr, msg) \
    `LFR_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

// ----- hw/rtl/lfr_pkg.sv -----
`timescale 1ns / 1ps
package lfr_pkg;

    localparam int NUM_BINS    = 52;
    localparam int UPPER_BINS  = 26;
    localparam int BIN_W       = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int TOP_RANKS   = 10;
    localparam int RANK_W      = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take_in;
        logic rd_bin;
        logic wr_inc;
        logic scan_start;
        logic scan_rd;
        logic pick;
        logic load_empty;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic present;
        logic is_letter;
        logic last;
        logic scan_last;
        logic found;
        logic out_final;
    } sts_t;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'd65) && (b <= 8'd90);
    endfunction

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= 8'd97) && (b <= 8'd122);
    endfunction

    function automatic logic [BIN_W-1:0] bin_of(input logic [7:0] b);
        logic [7:0] idx;
        if (is_upper(b)) begin
            idx = b - 8'd65;
        end else begin
            idx = b - 8'd97 + 8'(UPPER_BINS);
        end
        return idx[BIN_W-1:0];
    endfunction

    function automatic logic [7:0] code_of(input logic [BIN_W-1:0] bin);
        logic [7:0] wide;
        wide = 8'(bin);
        if (wide < 8'(UPPER_BINS)) begin
            return 8'd65 + wide;
        end else begin
            return 8'd97 + wide - 8'(UPPER_BINS);
        end
    endfunction

    function automatic logic [6:0] plain_of(input logic [RANK_W-1:0] rank);
        logic [6:0] code;
        unique case (rank)
            4'd0: code = 7'h45;
            4'd1: code = 7'h54;
            4'd2: code = 7'h41;
            4'd3: code = 7'h4F;
            4'd4: code = 7'h49;
            4'd5: code = 7'h4E;
            4'd6: code = 7'h53;
            4'd7: code = 7'h48;
            4'd8: code = 7'h52;
            4'd9: code = 7'h44;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/lfr_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfr_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfr_pkg::cmd_t    cmd,
    output lfr_pkg::sts_t    sts,
    input  logic [7:0]       s_text_byte,
    input  logic             s_byte_present,
    input  logic             s_end_of_text,
    output logic [3:0]       m_rank,
    output logic [6:0]       m_plain_letter,
    output logic [7:0]       m_cipher_letter,
    output logic [15:0]      m_letter_count,
    output logic             m_no_letters,
    output logic             m_final_result
);
    import lfr_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    valid_reg;
    logic [NUM_BINS-1:0]    picked_reg;

    logic [7:0]             byte_reg;
    logic                   present_reg;
    logic                   last_reg;

    logic [BIN_W-1:0]       bin_w;
    logic [BIN_W-1:0]       rd_addr;
    logic                   rd_en;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [COUNT_WIDTH-1:0] eff_cnt;

    logic [BIN_W-1:0]       ptr_reg;
    logic                   scan_pipe_reg;
    logic [BIN_W-1:0]       scan_bin_reg;
    logic                   better;

    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [BIN_W-1:0]       best_bin_reg;
    logic                   found_reg;
    logic [RANK_W-1:0]      rank_reg;

    logic [NUM_BINS-1:0]    best_onehot;
    logic                   none_left;
    logic [31:0]            best_wide;

    logic [3:0]             out_rank_reg;
    logic [6:0]             out_plain_reg;
    logic [7:0]             out_cipher_reg;
    logic [15:0]            out_count_reg;
    logic                   out_none_reg;
    logic                   out_final_reg;

    assign bin_w   = bin_of(byte_reg);
    assign rd_en   = cmd.rd_bin | cmd.scan_rd;
    assign rd_addr = cmd.scan_rd ? ptr_reg : bin_w;
    assign eff_cnt = rd_vld_reg ? rd_data_reg : '0;
    assign better  = scan_pipe_reg && !picked_reg[scan_bin_reg] && (eff_cnt > best_cnt_reg);

    assign best_onehot = NUM_BINS'(1) << best_bin_reg;
    assign none_left   = ~|(valid_reg & ~(picked_reg | best_onehot));
    assign best_wide   = 32'(best_cnt_reg);

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            byte_reg    <= s_text_byte;
            present_reg <= s_byte_present;
            last_reg    <= s_end_of_text;
        end
    end

    // count memory
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cnt_mem[rd_addr];
        end
        if (cmd.wr_inc) begin
            if (eff_cnt != {COUNT_WIDTH{1'b1}}) begin
                cnt_mem[bin_w] <= eff_cnt + COUNT_WIDTH'(1);
            end else begin
                cnt_mem[bin_w] <= eff_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            picked_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            ptr_reg       <= '0;
            scan_pipe_reg <= 1'b0;
            found_reg     <= 1'b0;
            rank_reg      <= '0;
        end else begin
            scan_pipe_reg <= cmd.scan_rd;
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (cmd.wr_inc) begin
                valid_reg[bin_w] <= 1'b1;
            end
            if (cmd.scan_start) begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end else if (cmd.scan_rd) begin
                ptr_reg <= ptr_reg + BIN_W'(1);
            end
            if (better) begin
                found_reg <= 1'b1;
            end
            if (cmd.pick) begin
                picked_reg <= picked_reg | best_onehot;
                rank_reg   <= rank_reg + RANK_W'(1);
            end
            if (cmd.clear) begin
                valid_reg  <= '0;
                picked_reg <= '0;
                rank_reg   <= '0;
            end
        end
    end

    // best candidate of the running scan
    always_ff @(posedge aclk) begin
        scan_bin_reg <= ptr_reg;
        if (cmd.scan_start) begin
            best_cnt_reg <= '0;
        end else if (better) begin
            best_cnt_reg <= eff_cnt;
            best_bin_reg <= scan_bin_reg;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            out_rank_reg   <= rank_reg;
            out_plain_reg  <= plain_of(rank_reg);
            out_cipher_reg <= code_of(best_bin_reg);
            out_count_reg  <= (best_wide > 32'h0000_FFFF) ? 16'hFFFF : best_wide[15:0];
            out_none_reg   <= 1'b0;
            out_final_reg  <= (rank_reg == RANK_W'(TOP_RANKS - 1)) || none_left;
        end else if (cmd.load_empty) begin
            out_rank_reg   <= '0;
            out_plain_reg  <= '0;
            out_cipher_reg <= '0;
            out_count_reg  <= '0;
            out_none_reg   <= 1'b1;
            out_final_reg  <= 1'b1;
        end
    end

    always_comb begin
        sts.present   = present_reg;
        sts.is_letter = is_upper(byte_reg) || is_lower(byte_reg);
        sts.last      = last_reg;
        sts.scan_last = (ptr_reg == BIN_W'(NUM_BINS - 1));
        sts.found     = found_reg;
        sts.out_final = out_final_reg;
    end

    assign m_rank          = out_rank_reg;
    assign m_plain_letter  = out_plain_reg;
    assign m_cipher_letter = out_cipher_reg;
    assign m_letter_count  = out_count_reg;
    assign m_no_letters    = out_none_reg;
    assign m_final_result  = out_final_reg;

    `LFR_ASSERT(a_pick_fresh, aclk, aresetn, cmd.pick |-> (found_reg && !picked_reg[best_bin_reg]), "pick of an empty or already ranked bin")
    `LFR_ASSERT(a_rank_bound, aclk, aresetn, rank_reg <= RANK_W'(TOP_RANKS), "rank beyond top ranks")
    `LFR_ASSERT(a_found_nonzero, aclk, aresetn, found_reg |-> (best_cnt_reg != '0), "best count zero while found")

endmodule

// ----- hw/rtl/lfr_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output lfr_pkg::cmd_t cmd,
    input  lfr_pkg::sts_t sts
);
    import lfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.present && sts.is_letter) begin
                    cmd.rd_bin = 1'b1;
                    state_next = ST_WRITE;
                end else if (sts.last) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: begin
                cmd.wr_inc = 1'b1;
                if (sts.last) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.found) begin
                    cmd.pick = 1'b1;
                end else begin
                    cmd.load_empty = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.out_final) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LFR_NEVER(a_one_side, aclk, aresetn, s_ready && m_valid, "input and result sides active together")

endmodule

// ----- hw/rtl/letter_frequency_top_rank_top.sv -----
`timescale 1ns / 1ps
// Letter frequency ranking. Each input word carries one text byte; A-Z and a-z are counted
// in 52 saturating 16-bit bins held in a count memory with a registered read port. A plain
// byte passes the steps accept and check, a letter accept, read and write back. On the word
// marked end_of_text the block ranks the letters by descending count, lower character code
// first on ties, and sends up to ten result words in rank order; each result costs one pass
// over the memory before its word is offered. A text without letters gives a single word
// with m_no_letters set. Counts are cleared for the next text as the final word is taken.
// No input word is accepted while a ranking run is in progress.
module letter_frequency_top_rank_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_rank,
    output logic [6:0]  m_plain_letter,
    output logic [7:0]  m_cipher_letter,
    output logic [15:0] m_letter_count,
    output logic        m_no_letters,
    output logic        m_final_result
);
    import lfr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lfr_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_text_byte     (s_text_byte),
        .s_byte_present  (s_byte_present),
        .s_end_of_text   (s_end_of_text),
        .m_rank          (m_rank),
        .m_plain_letter  (m_plain_letter),
        .m_cipher_letter (m_cipher_letter),
        .m_letter_count  (m_letter_count),
        .m_no_letters    (m_no_letters),
        .m_final_result  (m_final_result)
    );

endmodule
